[rtl/crp_pkg.sv]
// ----------------------------------------------------------------------------
// crp_pkg
// Shared constants, the arctangent table and the result type of the
// cartesian-to-polar radar core.
// ----------------------------------------------------------------------------
package crp_pkg;

  localparam int AngleBits    = 30;  // fraction bits of the angle accumulator
  localparam int PreScale     = 16;  // left shift of the coordinates into the rotator
  localparam int AtanLen      = 24;  // entries in the arctangent table
  localparam int ZWidth       = 36;  // angle accumulator width
  localparam int CordWidth    = 64;  // rotator datapath width
  localparam int SqrtStages   = 32;  // one root bit per stage
  localparam int DivSteps     = 32;  // one quotient bit per stage
  localparam int BearingWidth = 19;

  localparam logic signed [ZWidth-1:0] PiQ30 = 36'sd3373259426;
  localparam logic [15:0] RangeFloorReset = 16'd7;

  // atan(2^-i) in Q30, truncated, except entry 0, which is rounded up
  function automatic logic signed [ZWidth-1:0] atan_q30(input int unsigned idx);
    case (idx)
      0:       return 36'sd843314857;
      1:       return 36'sd497837829;
      2:       return 36'sd263043836;
      3:       return 36'sd133525158;
      4:       return 36'sd67021686;
      5:       return 36'sd33543515;
      6:       return 36'sd16775850;
      7:       return 36'sd8388437;
      8:       return 36'sd4194282;
      9:       return 36'sd2097149;
      10:      return 36'sd1048575;
      11:      return 36'sd524287;
      12:      return 36'sd262143;
      13:      return 36'sd131071;
      14:      return 36'sd65535;
      15:      return 36'sd32767;
      16:      return 36'sd16383;
      17:      return 36'sd8191;
      18:      return 36'sd4095;
      19:      return 36'sd2047;
      20:      return 36'sd1023;
      21:      return 36'sd511;
      22:      return 36'sd255;
      23:      return 36'sd127;
      default: return '0;
    endcase
  endfunction

  // Result item, range in the lowest bits
  typedef struct packed {
    logic [31:0]                    range_rate;
    logic signed [BearingWidth-1:0] bearing;
    logic [31:0]                    range;
  } crp_result_t;

endpackage

[rtl/cartesian_to_polar_radar_core.sv]
// ----------------------------------------------------------------------------
// cartesian_to_polar_radar_core
// Radar measurement function: range, bearing and range rate of a tracked
// target from its cartesian position and velocity.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  s_axis    in         tvalid / tready        tdata: pos_x, pos_y, vel_x, vel_y
//                                              tuser: is_radar
//  m_axis    out        tvalid / tready        tdata: range, bearing, range_rate
//  cfg       in         cfg_wr_en_i            cfg_wr_data_i: range_floor
//
//  One transaction per clock in and out while the skid register is empty;
//  each result passes 70 register stages, made of the capture, product and
//  sum stages, the 32-stage square root, the floor stage and the 34-stage
//  divider. The CORDIC runs beside the square root.
//  Reset clears all valid bits and loads range_floor with 7.
//  A stalled output parks one result in a skid register; the whole pipeline
//  holds while that register is full, so nothing is lost or repeated.
//  Non-radar transactions are accepted and dropped.
//
module cartesian_to_polar_radar_core #(
  parameter int FRACTION_BITS = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // configuration
  input  logic          cfg_wr_en_i,
  input  logic [15:0]   cfg_wr_data_i,   // range_floor
  // input stream
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [127:0]  s_axis_tdata_i,  // pos_x[31:0], pos_y[63:32], vel_x[95:64],
                                         // vel_y[127:96]
  input  logic          s_axis_tuser_i,  // is_radar
  // output stream
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [87:0]   m_axis_tdata_o   // range[31:0], bearing[50:32],
                                         // range_rate[82:51], zero pad[87:83]
);
  import crp_pkg::*;

  // bearing leaves the CORDIC ahead of the root and must meet the root
  // at the floor stage
  localparam int BrgDelay = SqrtStages - CORDIC_STAGES;
  localparam int DivSideW = BearingWidth + 32;

  // ---------------------------------------------------------------- config
  logic [15:0] floor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= RangeFloorReset;
    end else if (cfg_wr_en_i) begin
      floor_q <= cfg_wr_data_i;
    end
  end

  // ---------------------------------------------------------------- flow
  // The pipeline advances unless the skid register holds a result.
  logic        en;
  logic        skid_valid_q, skid_valid_d;
  crp_result_t skid_q, skid_d;

  assign en              = !skid_valid_q;
  assign s_axis_tready_o = en;

  // ---------------------------------------------------------------- stage 0
  logic               v0_q;
  logic signed [31:0] px0_q, py0_q, vx0_q, vy0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      // drop non-radar transactions here
      v0_q <= s_axis_tvalid_i && s_axis_tuser_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px0_q <= s_axis_tdata_i[31:0];
      py0_q <= s_axis_tdata_i[63:32];
      vx0_q <= s_axis_tdata_i[95:64];
      vy0_q <= s_axis_tdata_i[127:96];
    end
  end

  // ---------------------------------------------------------------- stage 1
  // four 32x32 products
  logic               v1_q;
  logic signed [63:0] pxx_q, pyy_q, p1_q, p2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pxx_q <= px0_q * px0_q;
      pyy_q <= py0_q * py0_q;
      p1_q  <= px0_q * vx0_q;
      p2_q  <= py0_q * vy0_q;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // sum of squares and sign-magnitude dot product
  logic        v2_q;
  logic [63:0] sq_q, mag_q;
  logic        neg_q;
  logic [63:0] m1, m2, mag_d;
  logic        n1, n2, neg_d;

  always_comb begin
    n1 = p1_q[63];
    n2 = p2_q[63];
    m1 = n1 ? 64'(-p1_q) : 64'(p1_q);
    m2 = n2 ? 64'(-p2_q) : 64'(p2_q);
    if (n1 == n2) begin
      mag_d = m1 + m2;
      neg_d = n1;
    end else if (m1 >= m2) begin
      mag_d = m1 - m2;
      neg_d = n1;
    end else begin
      mag_d = m2 - m1;
      neg_d = n2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q  <= 64'(pxx_q) + 64'(pyy_q);
      mag_q <= mag_d;
      neg_q <= neg_d;
    end
  end

  // ---------------------------------------------------------------- root
  logic        sq_valid;
  logic [31:0] root;
  logic [64:0] sq_side;

  crp_isqrt #(
    .SIDE_W (65)
  ) u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (v2_q),
    .radicand_i (sq_q),
    .side_i     ({neg_q, mag_q}),
    .valid_o    (sq_valid),
    .root_o     (root),
    .side_o     (sq_side)
  );

  // ---------------------------------------------------------------- bearing
  logic signed [BearingWidth-1:0] brg_cordic, brg_aligned;

  crp_cordic #(
    .FRACTION_BITS (FRACTION_BITS),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk_i     (clk_i),
    .en_i      (en),
    .pos_x_i   (px0_q),
    .pos_y_i   (py0_q),
    .bearing_o (brg_cordic)
  );

  crp_delay #(
    .WIDTH (BearingWidth),
    .DEPTH (BrgDelay)
  ) u_brg_delay (
    .clk_i  (clk_i),
    .en_i   (en),
    .data_i (brg_cordic),
    .data_o (brg_aligned)
  );

  // ---------------------------------------------------------------- floor
  // a floor register of zero acts as one
  logic        v3_q;
  logic [31:0] rho_q;
  logic [63:0] dmag_q;
  logic        dneg_q;
  logic signed [BearingWidth-1:0] brg_q;
  logic [31:0] floor_v;

  assign floor_v = (floor_q == '0) ? 32'd1 : 32'(floor_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rho_q  <= (root < floor_v) ? floor_v : root;
      dmag_q <= sq_side[63:0];
      dneg_q <= sq_side[64];
      brg_q  <= brg_aligned;
    end
  end

  // ---------------------------------------------------------------- divide
  logic                div_valid;
  logic [31:0]         rate;
  logic [DivSideW-1:0] div_side;
  crp_result_t         div_res;

  crp_divider #(
    .SIDE_W (DivSideW)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (v3_q),
    .dividend_i (dmag_q),
    .divisor_i  (rho_q),
    .neg_i      (dneg_q),
    .side_i     ({brg_q, rho_q}),
    .valid_o    (div_valid),
    .quot_o     (rate),
    .side_o     (div_side)
  );

  always_comb begin
    div_res.range      = div_side[31:0];
    div_res.bearing    = div_side[DivSideW-1:32];
    div_res.range_rate = rate;
  end

  // ---------------------------------------------------------------- skid
  // park the pipeline result when the sink stalls, drain it first after
  always_comb begin
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (m_axis_tready_i) begin
        skid_valid_d = 1'b0;
      end
    end else if (div_valid && !m_axis_tready_i) begin
      skid_valid_d = 1'b1;
      skid_d       = div_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else begin
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    skid_q <= skid_d;
  end

  assign m_axis_tvalid_o = skid_valid_q || div_valid;
  assign m_axis_tdata_o  = {5'b0, (skid_valid_q ? skid_q : div_res)};

  // ---------------------------------------------------------------- checks
  // range is floored at one or more
  a_range_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[31:0] != 32'd0))
    else $error("zero range delivered");

  // skid only loads from a stalled pipeline result
  a_skid_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(div_valid && !m_axis_tready_i))
    else $error("skid loaded without a stalled result");

  // pipeline output holds while the skid register is full
  a_pipe_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |=> ($stable(div_valid) && $stable(div_side)))
    else $error("pipeline advanced while skid full");

endmodule

[rtl/crp_delay.sv]
// ----------------------------------------------------------------------------
// crp_delay
// Stallable delay line that aligns a side result with the main pipeline.
// ----------------------------------------------------------------------------
module crp_delay #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] data_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= data_i;
    end
  end

  for (genvar i = 1; i < DEPTH; i++) begin : g_tap
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign data_o = tap_q[DEPTH-1];

endmodule

[rtl/crp_cordic.sv]
// ----------------------------------------------------------------------------
// crp_cordic
// Pipelined CORDIC in vectoring mode: atan2(y, x) rounded to the output
// fraction and clamped to +/- pi. The input, each rotation stage and the output are registered.
// ----------------------------------------------------------------------------
module crp_cordic #(
  parameter int FRACTION_BITS = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  output logic signed [crp_pkg::BearingWidth-1:0] bearing_o
);
  import crp_pkg::*;

  localparam int Stages = (CORDIC_STAGES < AtanLen) ? CORDIC_STAGES : AtanLen;
  localparam int Shift  = AngleBits - FRACTION_BITS;
  localparam logic signed [ZWidth-1:0] Half = ZWidth'(64'sd1 <<< (Shift - 1));
  localparam logic signed [ZWidth-1:0] PiF  = (PiQ30 + Half) >>> Shift;

  logic signed [CordWidth-1:0] x_q [Stages];
  logic signed [CordWidth-1:0] y_q [Stages];
  logic signed [ZWidth-1:0]    z_q [Stages+1];
  logic                        zero_q [Stages+1];

  logic signed [CordWidth-1:0] x0, y0;
  logic signed [ZWidth-1:0]    z0;

  // fold the left half plane onto the right one
  always_comb begin
    x0 = {{(CordWidth-32-PreScale){pos_x_i[31]}}, pos_x_i, {PreScale{1'b0}}};
    y0 = {{(CordWidth-32-PreScale){pos_y_i[31]}}, pos_y_i, {PreScale{1'b0}}};
    z0 = '0;
    if (x0[CordWidth-1]) begin
      z0 = y0[CordWidth-1] ? -PiQ30 : PiQ30;
      x0 = -x0;
      y0 = -y0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= x0;
      y_q[0]    <= y0;
      z_q[0]    <= z0;
      zero_q[0] <= (pos_x_i == '0) && (pos_y_i == '0);
    end
  end

  for (genvar i = 0; i < Stages; i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (!y_q[i][CordWidth-1]) begin
          z_q[i+1] <= z_q[i] + atan_q30(i);
        end else begin
          z_q[i+1] <= z_q[i] - atan_q30(i);
        end
      end
    end
    if (i < Stages - 1) begin : g_xy
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (!y_q[i][CordWidth-1]) begin
            x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
            y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          end else begin
            x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
            y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          end
        end
      end
    end
  end

  logic signed [ZWidth-1:0] z_rnd, z_clp;

  always_comb begin
    z_rnd = (z_q[Stages] + Half) >>> Shift;
    z_clp = z_rnd;
    if (z_rnd > PiF) z_clp = PiF;
    if (z_rnd < -PiF) z_clp = -PiF;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bearing_o <= zero_q[Stages] ? '0 : z_clp[BearingWidth-1:0];
    end
  end

endmodule

[rtl/crp_isqrt.sv]
// ----------------------------------------------------------------------------
// crp_isqrt
// Pipelined digit-by-digit integer square root of a 64-bit radicand, one
// root bit per stage, each stage registered.
// ----------------------------------------------------------------------------
module crp_isqrt #(
  parameter int SIDE_W = 65
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [63:0]       radicand_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [31:0]       root_o,
  output logic [SIDE_W-1:0] side_o
);
  import crp_pkg::*;

  logic [63:0]       rem_q  [SqrtStages-1];
  logic [31:0]       root_q [SqrtStages];
  logic [SIDE_W-1:0] side_q [SqrtStages];
  logic              vld_q  [SqrtStages];

  for (genvar k = 0; k < SqrtStages; k++) begin : g_stage
    localparam int B = SqrtStages - 1 - k;
    logic [63:0]       r_in;
    logic [31:0]       q_in;
    logic [SIDE_W-1:0] s_in;
    logic              v_in;
    logic [64:0]       trial;
    logic              take;

    if (k == 0) begin : g_first
      assign r_in = radicand_i;
      assign q_in = '0;
      assign s_in = side_i;
      assign v_in = valid_i;
    end else begin : g_next
      assign r_in = rem_q[k-1];
      assign q_in = root_q[k-1];
      assign s_in = side_q[k-1];
      assign v_in = vld_q[k-1];
    end

    assign trial = (65'(q_in) << (B + 1)) + (65'(1) << (2 * B));
    assign take  = {1'b0, r_in} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= take ? (q_in | (32'd1 << B)) : q_in;
        side_q[k] <= s_in;
      end
    end

    if (k < SqrtStages - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= take ? (r_in - trial[63:0]) : r_in;
        end
      end
    end
  end

  assign valid_o = vld_q[SqrtStages-1];
  assign root_o  = root_q[SqrtStages-1];
  assign side_o  = side_q[SqrtStages-1];

endmodule

[rtl/crp_divider.sv]
// ----------------------------------------------------------------------------
// crp_divider
// Pipelined restoring divider of a 64-bit magnitude by a 32-bit divisor,
// one quotient bit per stage, with signed saturation to 32 bits.
// The input, each step and the output are registered.
// ----------------------------------------------------------------------------
module crp_divider #(
  parameter int SIDE_W = 51
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [63:0]       dividend_i,
  input  logic [31:0]       divisor_i,
  input  logic              neg_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [31:0]       quot_o,
  output logic [SIDE_W-1:0] side_o
);
  import crp_pkg::*;

  logic [31:0]       rem_q [DivSteps];
  logic [31:0]       low_q [DivSteps];
  logic [31:0]       quo_q [DivSteps+1];
  logic [31:0]       dvs_q [DivSteps+1];
  logic              neg_q [DivSteps+1];
  logic              ovf_q [DivSteps+1];
  logic [SIDE_W-1:0] side_q [DivSteps+1];
  logic              vld_q [DivSteps+1];

  // quotient of 2^32 or more saturates whatever the sign
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= dividend_i[63:32];
      low_q[0]  <= dividend_i[31:0];
      quo_q[0]  <= '0;
      dvs_q[0]  <= divisor_i;
      neg_q[0]  <= neg_i;
      ovf_q[0]  <= dividend_i[63:32] >= divisor_i;
      side_q[0] <= side_i;
    end
  end

  for (genvar j = 0; j < DivSteps; j++) begin : g_step
    logic [32:0] part;
    logic        take;

    assign part = {rem_q[j], low_q[j][31]};
    assign take = part >= {1'b0, dvs_q[j]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[j+1]  <= {quo_q[j][30:0], take};
        dvs_q[j+1]  <= dvs_q[j];
        neg_q[j+1]  <= neg_q[j];
        ovf_q[j+1]  <= ovf_q[j];
        side_q[j+1] <= side_q[j];
      end
    end

    if (j < DivSteps - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j+1] <= take ? 32'(part - {1'b0, dvs_q[j]}) : part[31:0];
          low_q[j+1] <= {low_q[j][30:0], 1'b0};
        end
      end
    end
  end

  logic [31:0] q_fin, sat;

  always_comb begin
    q_fin = quo_q[DivSteps];
    if (neg_q[DivSteps]) begin
      if (ovf_q[DivSteps] || (q_fin > 32'h8000_0000)) begin
        sat = 32'h8000_0000;
      end else begin
        sat = -q_fin;
      end
    end else begin
      if (ovf_q[DivSteps] || q_fin[31]) begin
        sat = 32'h7FFF_FFFF;
      end else begin
        sat = q_fin;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= vld_q[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_o <= sat;
      side_o <= side_q[DivSteps];
    end
  end

endmodule

[bench/cartesian_to_polar_radar_core_test.sv]
// ----------------------------------------------------------------------------
// cartesian_to_polar_radar_core_test
// Self-checking bench for the radar measurement core: directed corner cases,
// then random position/velocity transactions with random idling on both
// streams, checked against an in-bench model of range, bearing and range rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cartesian_to_polar_radar_core_test;
  import crp_pkg::*;

  localparam int FracBits   = 16;
  localparam int Stages     = 16;
  localparam int Latency    = 71;
  localparam int WatchLimit = 4000;

  typedef struct packed {
    logic [31:0]       rng;
    logic signed [18:0] brg;
    logic [31:0]       rrate;
  } polar_t;

  // Expected polar results and their checking.
  class polar_scoreboard;
    polar_t pending[$];
    int     errors;
    logic [15:0] floor_reg;

    function new();
      errors    = 0;
      floor_reg = RangeFloorReset;
    endfunction

    function logic [63:0] root64(logic [63:0] n);
      logic [63:0] res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n   = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function logic signed [18:0] angle(longint px, longint py);
      longint x, y, z, t, pi_f, half;
      int     sh;
      sh = AngleBits - FracBits;
      z  = 0;
      if (px == 0 && py == 0) return 0;
      x = px <<< PreScale;
      y = py <<< PreScale;
      if (x < 0) begin
        z = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < ((Stages < AtanLen) ? Stages : AtanLen); i++) begin
        t = x;
        if (y >= 0) begin
          x = x + (y >>> i);
          y = y - (t >>> i);
          z = z + longint'(atan_q30(i));
        end else begin
          x = x - (y >>> i);
          y = y + (t >>> i);
          z = z - longint'(atan_q30(i));
        end
      end
      half = longint'(1) <<< (sh - 1);
      z    = (z + half) >>> sh;
      pi_f = (64'sd3373259426 + half) >>> sh;
      if (z > pi_f) z = pi_f;
      if (z < -pi_f) z = -pi_f;
      return z[18:0];
    endfunction

    // Note an accepted input transaction.
    function void note_input(logic radar, logic [127:0] d);
      longint px, py, vx, vy, p1, p2;
      logic [63:0] rho, fl, m1, m2, mag, q;
      logic   neg;
      polar_t e;
      if (!radar) return;
      px  = longint'($signed(d[31:0]));
      py  = longint'($signed(d[63:32]));
      vx  = longint'($signed(d[95:64]));
      vy  = longint'($signed(d[127:96]));
      // squares of 32-bit values fit in 63 bits, sum in 64 unsigned
      rho = root64(64'(px * px) + 64'(py * py));
      fl  = (floor_reg == 0) ? 64'd1 : 64'(floor_reg);
      if (rho < fl) rho = fl;
      p1  = px * vx;
      p2  = py * vy;
      m1  = (p1 < 0) ? 64'(-p1) : 64'(p1);
      m2  = (p2 < 0) ? 64'(-p2) : 64'(p2);
      if ((p1 < 0) == (p2 < 0)) begin
        mag = m1 + m2;
        neg = p1 < 0;
      end else if (m1 >= m2) begin
        mag = m1 - m2;
        neg = p1 < 0;
      end else begin
        mag = m2 - m1;
        neg = p2 < 0;
      end
      q = mag / rho;
      if (neg) begin
        if (q > 64'h8000_0000) q = 64'h8000_0000;
        q = 64'd0 - q;
      end else if (q > 64'h7FFF_FFFF) begin
        q = 64'h7FFF_FFFF;
      end
      e.rng   = rho[31:0];
      e.brg   = angle(px, py);
      e.rrate = q[31:0];
      pending.push_back(e);
    endfunction

    // Check one accepted result transaction.
    function void check_result(logic [87:0] d);
      polar_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", d);
        return;
      end
      e = pending.pop_front();
      if (d[31:0] !== e.rng || d[50:32] !== e.brg || d[82:51] !== e.rrate) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: range exp %h got %h, bearing exp %h got %h, rate exp %h got %h",
                   e.rng, d[31:0], e.brg, d[50:32], e.rrate, d[82:51]);
      end
    endfunction
  endclass

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         cfg_wr_en_i = 0;
  logic [15:0]  cfg_wr_data_i = 0;
  logic         s_axis_tvalid_i = 0;
  logic         s_axis_tready_o;
  logic [127:0] s_axis_tdata_i = 0;
  logic         s_axis_tuser_i = 0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 0;
  logic [87:0]  m_axis_tdata_o;

  polar_scoreboard board = new();
  bit  quiet_phase = 0;   // no idling in the last part of the run
  int  stall_cnt = 0;

  cartesian_to_polar_radar_core #(.FRACTION_BITS(FracBits), .CORDIC_STAGES(Stages)) dut (
    .clk_i, .rst_ni, .cfg_wr_en_i, .cfg_wr_data_i,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Sample the output stream; drive the receiver stalls in bursts.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) board.check_result(m_axis_tdata_o);
    if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      m_axis_tready_i <= 1'b0;
    end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
      stall_cnt <= $urandom_range(1, 11) - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Watchdog: end the run after too many cycles without any transaction.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("cartesian_to_polar_radar_core verification failed");
      $finish;
    end
  end

  // Send one transaction, holding it until accepted; idle first at random.
  task automatic send_item(logic radar, logic [127:0] d);
    if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= d;
    s_axis_tuser_i  <= radar;
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_input(radar, d);
  endtask

  task automatic go_idle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
    // dropped items may still be in flight
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  task automatic write_floor(logic [15:0] v);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= v;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    board.floor_reg = v;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return 32'($signed($urandom_range(0, 2000)) - 1000);
      2:       return 32'($signed($urandom_range(0, 4000000)) - 2000000);
      3:       return {32{$urandom_range(0, 1) == 1}} ^ $urandom_range(0, 15);
      default: return 32'($signed($urandom_range(0, 400000000)) - 200000000);
    endcase
  endfunction

  task automatic random_batch(int n);
    for (int k = 0; k < n; k++)
      send_item($urandom_range(0, 7) != 0,
                {rand_coord(), rand_coord(), rand_coord(), rand_coord()});
  endtask

  localparam logic [31:0] MaxV = 32'h7FFF_FFFF;
  localparam logic [31:0] MinV = 32'h8000_0000;

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero position, axes, negative x, extremes, non-radar drop.
    send_item(1'b1, {32'd5, 32'd3, 32'd0, 32'd0});
    send_item(1'b1, {32'd0, 32'd0, 32'd0, 32'h0001_0000});
    send_item(1'b1, {32'd0, 32'd0, 32'd0, 32'hFFFF_0000});
    send_item(1'b1, {32'd7, 32'd0, 32'd0, 32'hFFFF_0000});
    send_item(1'b1, {32'd0, 32'd0, 32'h0003_0000, 32'd0});
    send_item(1'b1, {32'd0, 32'd0, 32'hFFFD_0000, 32'd0});
    send_item(1'b1, {32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    send_item(1'b1, {MaxV, MaxV, MaxV, MaxV});
    send_item(1'b1, {MinV, MinV, MinV, MinV});
    send_item(1'b1, {MaxV, MinV, MinV, MaxV});
    send_item(1'b1, {MinV, MaxV, MaxV, MinV});
    send_item(1'b1, {MaxV, MaxV, 32'd1, 32'd1});
    send_item(1'b1, {MinV, MinV, 32'hFFFF_FFFF, 32'd0});
    send_item(1'b0, {MaxV, MaxV, MaxV, MaxV});
    send_item(1'b1, {32'h1234_5678, 32'h8765_4321, 32'h0000_0001, 32'h0000_0002});
    go_idle();

    // Sweep the floor register, extremes included.
    write_floor(16'd0);
    send_item(1'b1, {32'd9, 32'd9, 32'd0, 32'd0});
    random_batch(150);
    go_idle();
    write_floor(16'hFFFF);
    send_item(1'b1, {32'd9, 32'd9, 32'd0, 32'd0});
    random_batch(300);
    go_idle();
    write_floor(16'd1);
    random_batch(300);
    go_idle();
    write_floor(16'($urandom_range(2, 65534)));
    random_batch(300);
    go_idle();
    write_floor(RangeFloorReset);
    random_batch(300);
    quiet_phase = 1;
    random_batch(200);
    go_idle();

    if (board.errors == 0 && board.pending.size() == 0)
      $display("cartesian_to_polar_radar_core verification clean");
    else
      $display("cartesian_to_polar_radar_core verification failed");
    $finish;
  end

endmodule
